>>> rtl/ecc_pkg.sv
package ecc_pkg;

    // Offsets from the two epochs to 2000-01-01 00:00:00.
    localparam logic [31:0] NTP_TO_2000  = 32'd3155673600;
    localparam logic [31:0] UNIX_TO_2000 = 32'd946684800;

    // Divisors used while splitting the seconds count.
    localparam logic [5:0] DIV_MINUTE = 6'd60;
    localparam logic [5:0] DIV_HOUR   = 6'd24;

    // Day count after 2000 always fits 14 bits for 32-bit NTP input.
    localparam int DAYS_W = 14;

    // Action codes.
    localparam logic [1:0] ACT_DECODE   = 2'd0;
    localparam logic [1:0] ACT_ENC_NTP  = 2'd1;
    localparam logic [1:0] ACT_ENC_UNIX = 2'd2;

    // Top-level sequencer states.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ENC  = 5'b00010,
        S_DIV  = 5'b00100,
        S_WALK = 5'b01000,
        S_DONE = 5'b10000
    } ecc_state_t;

    // Date walk states.
    typedef enum logic [2:0] {
        W_IDLE  = 3'b001,
        W_YEAR  = 3'b010,
        W_MONTH = 3'b100
    } ecc_walk_t;

    // Days before the start of a month index (0 = January), non-leap year.
    function automatic logic [8:0] days_before_month(input logic [3:0] idx);
        logic [8:0] r;
        case (idx)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd59;
            4'd3:    r = 9'd90;
            4'd4:    r = 9'd120;
            4'd5:    r = 9'd151;
            4'd6:    r = 9'd181;
            4'd7:    r = 9'd212;
            4'd8:    r = 9'd243;
            4'd9:    r = 9'd273;
            4'd10:   r = 9'd304;
            4'd11:   r = 9'd334;
            default: r = 9'd365;
        endcase
        return r;
    endfunction

    // Length of a month (1 = January) in a non-leap year.
    function automatic logic [4:0] month_length(input logic [3:0] month);
        logic [4:0] r;
        case (month)
            4'd2:    r = 5'd28;
            4'd4:    r = 5'd30;
            4'd6:    r = 5'd30;
            4'd9:    r = 5'd30;
            4'd11:   r = 5'd30;
            default: r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/ecc_serial_div.sv
module ecc_serial_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [5:0]  divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [5:0]  remainder
);
    import ecc_pkg::*;

    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] work_reg, work_next;
    logic [5:0]  rem_reg, rem_next;
    logic [5:0]  div_reg, div_next;
    logic [6:0]  trial;
    logic        fits;

    // One quotient bit per cycle: shift in the next dividend bit and try the divisor.
    assign trial = {rem_reg, work_reg[31]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            run_next  = 1'b1;
            cnt_next  = 5'd0;
            work_next = dividend;
            rem_next  = 6'd0;
            div_next  = divisor;
        end
        else if (run_reg)
        begin
            rem_next  = fits ? 6'(trial - {1'b0, div_reg}) : trial[5:0];
            work_next = {work_reg[30:0], fits};
            cnt_next  = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = work_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/ecc_date_walk.sv
module ecc_date_walk (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ecc_pkg::DAYS_W-1:0] days_in,
    output logic                      done,
    output logic [6:0]                year,
    output logic [3:0]                month,
    output logic [4:0]                day
);
    import ecc_pkg::*;

    ecc_walk_t          state_reg, state_next;
    logic               done_reg, done_next;
    logic [DAYS_W-1:0]  days_reg, days_next;
    logic [6:0]         year_reg, year_next;
    logic [3:0]         month_reg, month_next;
    logic               leap;
    logic [8:0]         year_len;
    logic [4:0]         mon_len;

    // Every fourth year from 2000 on is a leap year.
    assign leap     = (year_reg[1:0] == 2'd0);
    assign year_len = leap ? 9'd366 : 9'd365;
    assign mon_len  = month_length(month_reg) +
                      ((leap && month_reg == 4'd2) ? 5'd1 : 5'd0);

    // Take off one whole year, then one whole month, per cycle.
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        days_next  = days_reg;
        year_next  = year_reg;
        month_next = month_reg;
        unique case (state_reg)
            W_IDLE:
            begin
                if (start)
                begin
                    days_next  = days_in;
                    year_next  = 7'd0;
                    month_next = 4'd1;
                    state_next = W_YEAR;
                end
            end
            W_YEAR:
            begin
                if (days_reg < DAYS_W'(year_len))
                    state_next = W_MONTH;
                else
                begin
                    days_next = days_reg - DAYS_W'(year_len);
                    year_next = year_reg + 7'd1;
                end
            end
            W_MONTH:
            begin
                if (days_reg < DAYS_W'(mon_len) || month_reg >= 4'd12)
                begin
                    state_next = W_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    days_next  = days_reg - DAYS_W'(mon_len);
                    month_next = month_reg + 4'd1;
                end
            end
            default:
                state_next = W_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        days_reg  <= days_next;
        year_reg  <= year_next;
        month_reg <= month_next;
    end

    assign done  = done_reg;
    assign year  = year_reg;
    assign month = month_reg;
    assign day   = days_reg[4:0] + 5'd1;

endmodule

>>> rtl/epoch_seconds_calendar_converter.sv
// Encode runs through the S_ENC steps from accept to result; decode runs three bit-serial divisions
// and then a date walk that takes off one elapsed year or month at a time.
// An out-of-range decode or an unused action goes from S_IDLE straight to S_DONE.
// Throughput: one item at a time; a new item is accepted while the last result waits.
// Reset (rst_n, asynchronous, active low) clears the sequencer and submodule state and empties the output.
module epoch_seconds_calendar_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // seconds_in[31:0], year_in[38:32], month_in[42:39], day_in[47:43],
    // hour_in[52:48], minute_in[58:53], second_in[64:59], zero fill above
    input  logic [71:0] s_axis_tdata,
    // action[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // seconds_out[31:0], year_out[38:32], month_out[42:39], day_out[47:43],
    // hour_out[52:48], minute_out[58:53], second_out[64:59], zero fill above
    output logic [71:0] m_axis_tdata,
    // range_error[0]
    output logic        m_axis_tuser
);
    import ecc_pkg::*;

    ecc_state_t  state_reg, state_next;
    logic [1:0]  act_reg;
    logic [6:0]  y_reg;
    logic [3:0]  mo_reg;
    logic [4:0]  d_reg, h_reg;
    logic [5:0]  mi_reg, s_reg;
    logic        err_reg, err_next;
    logic [2:0]  step_reg, step_next;
    logic [1:0]  dix_reg, dix_next;
    logic [31:0] acc_reg, acc_next;
    logic [4:0]  hr_reg;
    logic [5:0]  mn_reg, sc_reg;

    logic        ov_reg;
    logic [71:0] od_reg;
    logic        oe_reg;

    logic        accept, load;
    logic [31:0] t_in, t_off;
    logic        div_start, div_done, walk_start, walk_done;
    logic [31:0] div_dividend, div_q;
    logic [5:0]  div_divisor, div_r;
    logic [6:0]  w_year;
    logic [3:0]  w_month;
    logic [4:0]  w_day;
    logic [3:0]  whole;
    logic        adj;
    logic [31:0] enc_base;

    assign t_in   = s_axis_tdata[31:0];
    assign t_off  = t_in - NTP_TO_2000;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign load   = (state_reg == S_DONE) && (!ov_reg || m_axis_tready);

    // Whole months before the given one and the leap day, as the calendar counts them.
    assign whole = (mo_reg == 4'd0) ? 4'd0 : ((mo_reg > 4'd13) ? 4'd12 : mo_reg - 4'd1);
    assign adj   = (mo_reg > 4'd2) && (y_reg[1:0] == 2'd0);
    assign enc_base = 32'(d_reg) + 32'(days_before_month(whole)) + 32'(adj)
                    + 32'((8'(y_reg) + 8'd3) >> 2) - 32'd1;

    // Divider chain: seconds by 60, minutes by 60, hours by 24.
    assign div_start    = (accept && s_axis_tuser == ACT_DECODE && t_in >= NTP_TO_2000) ||
                          (state_reg == S_DIV && div_done && dix_reg != 2'd2);
    assign div_dividend = (state_reg == S_IDLE) ? t_off : div_q;
    assign div_divisor  = ((state_reg == S_DIV && dix_reg == 2'd1) ||
                           (state_reg == S_DIV && dix_reg == 2'd2 && !div_done))
                          ? DIV_HOUR : DIV_MINUTE;
    assign walk_start   = (state_reg == S_DIV) && div_done && (dix_reg == 2'd2);

    ecc_serial_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    ecc_date_walk u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (walk_start),
        .days_in (div_q[DAYS_W-1:0]),
        .done    (walk_done),
        .year    (w_year),
        .month   (w_month),
        .day     (w_day)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        err_next   = err_reg;
        step_next  = step_reg;
        dix_next   = dix_reg;
        acc_next   = acc_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    err_next  = 1'b0;
                    step_next = 3'd0;
                    dix_next  = 2'd0;
                    acc_next  = 32'd0;
                    if (s_axis_tuser == ACT_ENC_NTP || s_axis_tuser == ACT_ENC_UNIX)
                        state_next = S_ENC;
                    else if (s_axis_tuser == ACT_DECODE)
                    begin
                        if (t_in < NTP_TO_2000)
                        begin
                            err_next   = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                            state_next = S_DIV;
                    end
                    else
                        state_next = S_DONE;
                end
            end
            S_ENC:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0: acc_next = enc_base;
                    3'd1: acc_next = acc_reg + 32'(9'd365 * 16'(y_reg));
                    3'd2: acc_next = (acc_reg << 4) + (acc_reg << 3) + 32'(h_reg);
                    3'd3: acc_next = (acc_reg << 6) - (acc_reg << 2) + 32'(mi_reg);
                    3'd4: acc_next = (acc_reg << 6) - (acc_reg << 2) + 32'(s_reg);
                    default:
                    begin
                        acc_next   = acc_reg +
                                     ((act_reg == ACT_ENC_NTP) ? NTP_TO_2000 : UNIX_TO_2000);
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    dix_next = dix_reg + 2'd1;
                    if (dix_reg == 2'd2)
                        state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (walk_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                ov_reg <= 1'b1;
            else if (m_axis_tready)
                ov_reg <= 1'b0;
        end
    end

    // Item capture, working registers and the output register.
    always_ff @(posedge clk)
    begin
        err_reg  <= err_next;
        step_reg <= step_next;
        dix_reg  <= dix_next;
        acc_reg  <= acc_next;
        if (accept)
        begin
            act_reg <= s_axis_tuser;
            y_reg   <= s_axis_tdata[38:32];
            mo_reg  <= s_axis_tdata[42:39];
            d_reg   <= s_axis_tdata[47:43];
            h_reg   <= s_axis_tdata[52:48];
            mi_reg  <= s_axis_tdata[58:53];
            s_reg   <= s_axis_tdata[64:59];
        end
        if (state_reg == S_DIV && div_done)
        begin
            case (dix_reg)
                2'd0:    sc_reg <= div_r;
                2'd1:    mn_reg <= div_r;
                default: hr_reg <= div_r[4:0];
            endcase
        end
        if (load)
        begin
            oe_reg <= err_reg;
            if (act_reg == ACT_DECODE && !err_reg)
                od_reg <= {7'd0, sc_reg, mn_reg, hr_reg, w_day, w_month, w_year, 32'd0};
            else if (act_reg == ACT_ENC_NTP || act_reg == ACT_ENC_UNIX)
                od_reg <= {40'd0, acc_reg};
            else
                od_reg <= 72'd0;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = oe_reg;

endmodule
